// File: rtl/core/bc13_pkg.sv
`timescale 1ns / 1ps
package bc13_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PIXELS = 16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] RECIP3 = 8'd171;
  localparam logic [11:0] RECIP7 = 12'd2341;
  localparam logic [11:0] RECIP5 = 12'd3277;

  typedef struct packed {
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
  } rgb565_t;

  typedef struct packed {
    logic bc3;
    rgb565_t [3:0] cpal;
    logic [7:0][7:0] apal;
    logic [31:0] cidx;
    logic [47:0] aidx;
  } blk_t;

  // Exact for every value below 192.
  function automatic logic [5:0] div3(input logic [7:0] x);
    logic [15:0] p;
    p = x * RECIP3;
    return p[14:9];
  endfunction

  // Exact for every value below 1792.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = x * RECIP7;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = x * RECIP5;
    return p[21:14];
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] t;
    t = {c, 8'b0} - {8'b0, c};
    return t[12:5];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] t;
    t = {c, 8'b0} - {8'b0, c};
    return t[13:6];
  endfunction

endpackage

// File: rtl/core/bc1_bc3_texture_block_decoder_core.sv
`timescale 1ns / 1ps
// Decodes one BC1 or BC3 compressed 4x4 block per transfer on the block channel and
// delivers its sixteen pixels in row order as 8-bit RGBA, one pixel per cycle on the
// pixel channel while it is ready and a block is waiting in the queue. The front end
// computes both palettes in a two-stage pipeline and places finished blocks in a
// two-entry queue, so new blocks are taken while earlier ones are still being emitted.
// A block passes through both pipeline stages and the queue before the registered
// pixel output presents its first pixel. The format register selects BC3 when
// set and must only be written while the decoder is idle.
module bc1_bc3_texture_block_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        blk_valid,
  output logic        blk_ready,
  input  logic [63:0] colour_block,
  input  logic [63:0] alpha_block,
  output logic        pix_valid,
  input  logic        pix_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [3:0]  pixel_position,
  output logic        last_pixel
);
  import bc13_pkg::*;

  logic format_bc3;
  logic push_valid;
  logic push_ready;
  blk_t push_data;
  logic head_valid;
  blk_t head_data;
  logic pop;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_bc3 <= 1'b0;
    end else if (cfg_write_en) begin
      format_bc3 <= cfg_write_data;
    end
  end

  bc13_front u_front (
    .clk          (clk),
    .rst          (rst),
    .format_bc3   (format_bc3),
    .blk_valid    (blk_valid),
    .blk_ready    (blk_ready),
    .colour_block (colour_block),
    .alpha_block  (alpha_block),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  bc13_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data),
    .count      (q_count)
  );

  bc13_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .pix_valid      (pix_valid),
    .pix_ready      (pix_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .pixel_position (pixel_position),
    .last_pixel     (last_pixel)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (pix_valid && last_pixel && (pixel_position == 4'(PIXELS - 1))))
    else $error("block retired without its last pixel");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !blk_ready |-> (push_valid && !push_ready))
    else $error("block channel stalled while the queue had room");

endmodule

// File: rtl/core/bc13_front.sv
`timescale 1ns / 1ps
module bc13_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           format_bc3,
  input  logic           blk_valid,
  output logic           blk_ready,
  input  logic [63:0]    colour_block,
  input  logic [63:0]    alpha_block,
  output logic           push_valid,
  input  logic           push_ready,
  output bc13_pkg::blk_t push_data
);
  import bc13_pkg::*;

  logic adv1;
  logic adv2;

  rgb565_t e0;
  rgb565_t e1;
  logic [7:0] a0;
  logic [7:0] a1;
  logic four_next;
  logic agt_next;
  logic [6:0] cr2_next;
  logic [6:0] cr3_next;
  logic [7:0] cg2_next;
  logic [7:0] cg3_next;
  logic [6:0] cb2_next;
  logic [6:0] cb3_next;
  logic [5:0][10:0] anum_next;

  logic s1_valid;
  logic s1_bc3;
  logic s1_four;
  logic s1_agt;
  rgb565_t s1_e0;
  rgb565_t s1_e1;
  logic [7:0] s1_a0;
  logic [7:0] s1_a1;
  logic [6:0] s1_cr2;
  logic [6:0] s1_cr3;
  logic [7:0] s1_cg2;
  logic [7:0] s1_cg3;
  logic [6:0] s1_cb2;
  logic [6:0] s1_cb3;
  logic [5:0][10:0] s1_anum;
  logic [31:0] s1_cidx;
  logic [47:0] s1_aidx;

  blk_t blk_next;
  logic s2_valid;
  blk_t s2;

  assign adv2 = !s2_valid || push_ready;
  assign adv1 = !s1_valid || adv2;
  assign blk_ready = adv1;
  assign push_valid = s2_valid;
  assign push_data = s2;

  always_comb begin
    e0 = rgb565_t'(colour_block[15:0]);
    e1 = rgb565_t'(colour_block[31:16]);
    a0 = alpha_block[7:0];
    a1 = alpha_block[15:8];
    four_next = format_bc3 || (colour_block[15:0] > colour_block[31:16]);
    agt_next = a0 > a1;
    if (four_next) begin
      cr2_next = 7'({e0.r, 1'b0}) + 7'(e1.r);
      cr3_next = 7'(e0.r) + 7'({e1.r, 1'b0});
      cg2_next = 8'({e0.g, 1'b0}) + 8'(e1.g);
      cg3_next = 8'(e0.g) + 8'({e1.g, 1'b0});
      cb2_next = 7'({e0.b, 1'b0}) + 7'(e1.b);
      cb3_next = 7'(e0.b) + 7'({e1.b, 1'b0});
    end else begin
      cr2_next = 7'(e0.r) + 7'(e1.r);
      cr3_next = '0;
      cg2_next = 8'(e0.g) + 8'(e1.g);
      cg3_next = '0;
      cb2_next = 7'(e0.b) + 7'(e1.b);
      cb3_next = '0;
    end
    for (int k = 0; k < 6; k++) begin
      if (agt_next) begin
        anum_next[k] = 11'((6 - k) * a0) + 11'((k + 1) * a1);
      end else if (k < 4) begin
        anum_next[k] = 11'((4 - k) * a0) + 11'((k + 1) * a1);
      end else begin
        anum_next[k] = '0;
      end
    end
  end

  always_comb begin
    blk_next.bc3 = s1_bc3;
    blk_next.cidx = s1_cidx;
    blk_next.aidx = s1_aidx;
    blk_next.cpal[0] = s1_e0;
    blk_next.cpal[1] = s1_e1;
    if (s1_four) begin
      blk_next.cpal[2].r = 5'(div3(8'(s1_cr2)));
      blk_next.cpal[2].g = div3(s1_cg2);
      blk_next.cpal[2].b = 5'(div3(8'(s1_cb2)));
      blk_next.cpal[3].r = 5'(div3(8'(s1_cr3)));
      blk_next.cpal[3].g = div3(s1_cg3);
      blk_next.cpal[3].b = 5'(div3(8'(s1_cb3)));
    end else begin
      blk_next.cpal[2].r = s1_cr2[5:1];
      blk_next.cpal[2].g = s1_cg2[6:1];
      blk_next.cpal[2].b = s1_cb2[5:1];
      blk_next.cpal[3] = '0;
    end
    blk_next.apal[0] = s1_a0;
    blk_next.apal[1] = s1_a1;
    for (int k = 0; k < 6; k++) begin
      if (s1_agt) begin
        blk_next.apal[k + 2] = div7(s1_anum[k]);
      end else if (k < 4) begin
        blk_next.apal[k + 2] = div5(s1_anum[k]);
      end else if (k == 4) begin
        blk_next.apal[k + 2] = '0;
      end else begin
        blk_next.apal[k + 2] = ALPHA_OPAQUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= blk_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && blk_valid) begin
      s1_bc3 <= format_bc3;
      s1_four <= four_next;
      s1_agt <= agt_next;
      s1_e0 <= e0;
      s1_e1 <= e1;
      s1_a0 <= a0;
      s1_a1 <= a1;
      s1_cr2 <= cr2_next;
      s1_cr3 <= cr3_next;
      s1_cg2 <= cg2_next;
      s1_cg3 <= cg3_next;
      s1_cb2 <= cb2_next;
      s1_cb3 <= cb3_next;
      s1_anum <= anum_next;
      s1_cidx <= colour_block[63:32];
      s1_aidx <= alpha_block[63:16];
    end
    if (adv2 && s1_valid) begin
      s2 <= blk_next;
    end
  end

endmodule

// File: rtl/core/bc13_queue.sv
`timescale 1ns / 1ps
module bc13_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  bc13_pkg::blk_t          push_data,
  output logic                    head_valid,
  input  logic                    pop,
  output bc13_pkg::blk_t          head_data,
  output logic [bc13_pkg::QCNT_W-1:0] count
);
  import bc13_pkg::*;

  blk_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic do_push;
  logic do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/bc13_back.sv
`timescale 1ns / 1ps
module bc13_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  bc13_pkg::blk_t head_data,
  output logic           pop,
  output logic           pix_valid,
  input  logic           pix_ready,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic [7:0]     alpha,
  output logic [3:0]     pixel_position,
  output logic           last_pixel
);
  import bc13_pkg::*;

  logic [3:0] cnt;
  logic load;
  logic [4:0] cbase;
  logic [5:0] abase;
  logic [1:0] ci;
  logic [2:0] ai;
  rgb565_t sel;
  logic [7:0] alpha_next;

  assign load = head_valid && (!pix_valid || pix_ready);
  assign pop = load && (cnt == 4'(PIXELS - 1));

  always_comb begin
    cbase = {cnt, 1'b0};
    abase = {1'b0, cnt, 1'b0} + {2'b0, cnt};
    ci = head_data.cidx[cbase +: 2];
    ai = head_data.aidx[abase +: 3];
    sel = head_data.cpal[ci];
    alpha_next = head_data.bc3 ? head_data.apal[ai] : ALPHA_OPAQUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      pix_valid <= 1'b1;
      cnt <= cnt + 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red <= expand5(sel.r);
      green <= expand6(sel.g);
      blue <= expand5(sel.b);
      alpha <= alpha_next;
      pixel_position <= cnt;
      last_pixel <= cnt == 4'(PIXELS - 1);
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bc13_pkg::*;

  localparam logic FMT_BC1 = 1'b0;
  localparam logic FMT_BC3 = 1'b1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_WAIT_LIMIT = 50000;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic [3:0] pos;
    logic       last;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic        cfg_write_data;
  logic        blk_valid;
  logic        blk_ready;
  logic [63:0] colour_block;
  logic [63:0] alpha_block;
  logic        pix_valid;
  logic        pix_ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [3:0]  pixel_position;
  logic        last_pixel;

  pixel_t expected_pixels[$];
  pixel_t next_pixel;
  logic   format_now;
  int     send_gap_pct;
  int     stall_pct;
  int     hold_cycles;
  int     error_count;
  int     cycle_count;
  int     blocks_sent;
  int     bc3_blocks;
  int     pixels_seen;

  bc1_bc3_texture_block_decoder_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .blk_valid(blk_valid),
    .blk_ready(blk_ready),
    .colour_block(colour_block),
    .alpha_block(alpha_block),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .alpha(alpha),
    .pixel_position(pixel_position),
    .last_pixel(last_pixel)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTED) begin
      $display("Mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    error_count = error_count + 1;
  endtask

  // Decodes one block into the sixteen pixels it should produce.
  function automatic void predict_block_pixels(input logic [63:0] cb, input logic [63:0] ab,
                                               input logic bc3);
    int unsigned r0, g0, b0, r1, g1, b1, a0, a1, ci, ai, k;
    int unsigned pr[4];
    int unsigned pg[4];
    int unsigned pb[4];
    int unsigned apal[8];
    logic four_colour;
    pixel_t px;
    r0 = cb[15:11];
    g0 = cb[10:5];
    b0 = cb[4:0];
    r1 = cb[31:27];
    g1 = cb[26:21];
    b1 = cb[20:16];
    four_colour = (bc3 == FMT_BC3) || (cb[15:0] > cb[31:16]);
    pr[0] = r0; pg[0] = g0; pb[0] = b0;
    pr[1] = r1; pg[1] = g1; pb[1] = b1;
    if (four_colour) begin
      pr[2] = (2 * r0 + r1) / 3;
      pg[2] = (2 * g0 + g1) / 3;
      pb[2] = (2 * b0 + b1) / 3;
      pr[3] = (r0 + 2 * r1) / 3;
      pg[3] = (g0 + 2 * g1) / 3;
      pb[3] = (b0 + 2 * b1) / 3;
    end else begin
      pr[2] = (r0 + r1) / 2;
      pg[2] = (g0 + g1) / 2;
      pb[2] = (b0 + b1) / 2;
      pr[3] = 0; pg[3] = 0; pb[3] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      pr[i] = (255 * pr[i]) / 32;
      pg[i] = (255 * pg[i]) / 64;
      pb[i] = (255 * pb[i]) / 32;
    end
    a0 = ab[7:0];
    a1 = ab[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (k = 0; k < 6; k++) begin
        apal[k + 2] = ((6 - k) * a0 + (k + 1) * a1) / 7;
      end
    end else begin
      for (k = 0; k < 4; k++) begin
        apal[k + 2] = ((4 - k) * a0 + (k + 1) * a1) / 5;
      end
      apal[6] = 0;
      apal[7] = 255;
    end
    for (int i = 0; i < PIXELS; i++) begin
      ci = cb[32 + 2 * i +: 2];
      ai = ab[16 + 3 * i +: 3];
      px.r = 8'(pr[ci]);
      px.g = 8'(pg[ci]);
      px.b = 8'(pb[ci]);
      px.a = (bc3 == FMT_BC3) ? 8'(apal[ai]) : 8'd255;
      px.pos = 4'(i);
      px.last = (i == PIXELS - 1);
      expected_pixels = {expected_pixels, px};
    end
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      pix_ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      pix_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_valid && pix_ready) begin
      pixels_seen = pixels_seen + 1;
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with no block pending, position", pixel_position, -1);
      end else begin
        next_pixel = expected_pixels.pop_front();
        if (red !== next_pixel.r) report_mismatch("red", red, next_pixel.r);
        if (green !== next_pixel.g) report_mismatch("green", green, next_pixel.g);
        if (blue !== next_pixel.b) report_mismatch("blue", blue, next_pixel.b);
        if (alpha !== next_pixel.a) report_mismatch("alpha", alpha, next_pixel.a);
        if (pixel_position !== next_pixel.pos) begin
          report_mismatch("pixel_position", pixel_position, next_pixel.pos);
        end
        if (last_pixel !== next_pixel.last) begin
          report_mismatch("last_pixel", last_pixel, next_pixel.last);
        end
      end
    end
  end

  task automatic send_block(input logic [63:0] cb, input logic [63:0] ab);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      blk_valid = 1'b0;
      @(negedge clk);
    end
    blk_valid = 1'b1;
    colour_block = cb;
    alpha_block = ab;
    do @(posedge clk); while (!blk_ready);
    predict_block_pixels(cb, ab, format_now);
    blocks_sent = blocks_sent + 1;
    if (format_now == FMT_BC3) bc3_blocks = bc3_blocks + 1;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    blk_valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_format(input logic fmt);
    wait_for_drain();
    cfg_write_en = 1'b1;
    cfg_write_data = fmt;
    @(negedge clk);
    cfg_write_en = 1'b0;
    format_now = fmt;
  endtask

  // Pixel i selects palette entry i mod 8.
  function automatic logic [47:0] alpha_index_ramp();
    logic [47:0] idx;
    for (int i = 0; i < PIXELS; i++) idx[3 * i +: 3] = 3'(i);
    return idx;
  endfunction

  function automatic logic [63:0] random_colour_block();
    logic [63:0] cb;
    logic [15:0] tmp;
    cb = {$urandom, $urandom};
    case ($urandom_range(3))
      0: cb[31:16] = cb[15:0];
      1: if (cb[15:0] > cb[31:16]) begin
        tmp = cb[15:0];
        cb[15:0] = cb[31:16];
        cb[31:16] = tmp;
      end
      2: if (cb[15:0] < cb[31:16]) begin
        tmp = cb[15:0];
        cb[15:0] = cb[31:16];
        cb[31:16] = tmp;
      end
      default: ;
    endcase
    return cb;
  endfunction

  function automatic logic [63:0] random_alpha_block();
    logic [63:0] ab;
    logic [7:0] tmp;
    ab = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ab[15:8] = ab[7:0];
      1: if (ab[7:0] > ab[15:8]) begin
        tmp = ab[7:0];
        ab[7:0] = ab[15:8];
        ab[15:8] = tmp;
      end
      2: if (ab[7:0] < ab[15:8]) begin
        tmp = ab[7:0];
        ab[7:0] = ab[15:8];
        ab[15:8] = tmp;
      end
      default: ;
    endcase
    return ab;
  endfunction

  task automatic test_bc1_four_colour();
    set_format(FMT_BC1);
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
    send_block({$urandom, 16'h07E0, 16'hF800}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({32'hFFFFFFFF, 16'h0000, 16'h0001}, 64'd0);
    send_block({32'h1B1B1B1B, 16'h001F, 16'hF81F}, 64'd0);
  endtask

  task automatic test_bc1_three_colour();
    send_block(64'd0, 64'd0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, {$urandom, $urandom});
    send_block({32'h1B1B1B1B, 16'hF81F, 16'h07E0}, {$urandom, $urandom});
    send_block({32'hE4E4E4E4, 16'h8410, 16'h8410}, 64'd0);
  endtask

  task automatic test_bc3_alpha_palette();
    set_format(FMT_BC3);
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {alpha_index_ramp(), 8'h00, 8'hFF});
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, {alpha_index_ramp(), 8'hFF, 8'h00});
    send_block({32'h1B1B1B1B, 16'h1234, 16'h1234}, {alpha_index_ramp(), 8'h80, 8'h80});
    send_block({32'hE4E4E4E4, 16'h07E0, 16'hF81F}, {alpha_index_ramp(), 8'h00, 8'h01});
    send_block({32'hE4E4E4E4, 16'hF800, 16'h001F}, {alpha_index_ramp(), 8'hC8, 8'h0A});
    send_block(64'd0, 64'd0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_block(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random_traffic(input int count, input int gap, input int stall,
                                     input logic fmt);
    set_format(fmt);
    send_gap_pct = gap;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      send_block(random_colour_block(), random_alpha_block());
    end
    wait_for_drain();
    send_gap_pct = 0;
    stall_pct = 0;
  endtask

  // The output stays blocked long enough for the input side to back up.
  task automatic test_output_hold_off();
    set_format(FMT_BC3);
    hold_cycles = 300;
    for (int n = 0; n < 12; n++) begin
      send_block(random_colour_block(), random_alpha_block());
    end
    wait_for_drain();
  endtask

  initial begin
    int end_wait;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = 1'b0;
    blk_valid = 1'b0;
    colour_block = 64'd0;
    alpha_block = 64'd0;
    pix_ready = 1'b0;
    format_now = FMT_BC1;
    send_gap_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    error_count = 0;
    cycle_count = 0;
    blocks_sent = 0;
    bc3_blocks = 0;
    pixels_seen = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_bc1_four_colour();
    test_bc1_three_colour();
    test_bc3_alpha_palette();
    test_output_hold_off();
    test_random_traffic(92, 0, 0, FMT_BC1);
    test_random_traffic(92, 83, 0, FMT_BC3);
    test_random_traffic(92, 0, 83, FMT_BC1);
    test_random_traffic(92, 37, 37, FMT_BC3);

    end_wait = 0;
    while (expected_pixels.size() != 0 && end_wait < END_WAIT_LIMIT) begin
      @(posedge clk);
      end_wait = end_wait + 1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      report_mismatch("pixels never delivered", 0, expected_pixels.size());
    end
    $display("Decoded %0d blocks (%0d in BC3 mode), %0d pixels checked, %0d mismatches.",
             blocks_sent, bc3_blocks, pixels_seen, error_count);
    $display("Covered three- and four-color blocks, both alpha palettes and back-pressure.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: bc1_bc3_texture_block_decoder_core.f
rtl/core/bc13_pkg.sv
rtl/core/bc13_front.sv
rtl/core/bc13_queue.sv
rtl/core/bc13_back.sv
rtl/core/bc1_bc3_texture_block_decoder_core.sv
sim/testbench.sv
